// ===== rtl/wec_pkg.sv =====
// Shared types, constants and functions of the Ethernet controller register block.
package wec_pkg;

  localparam int unsigned FIFO_WORDS_DEF = 16;
  localparam int unsigned IBUF_WORDS_DEF = 1024;

  localparam logic [15:0] START_DELIM   = 16'h55d5;
  localparam logic [31:0] CRC_POLY      = 32'h04C11DB7;
  localparam logic [31:0] CRC_PRESET    = 32'hFFFFFFFF;
  localparam logic [31:0] RESIDUE_RESET = 32'hC704DD7B;

  typedef enum logic [3:0] {
    MODE_OUTCTL   = 4'd0,
    MODE_INCTL    = 4'd1,
    MODE_OUTDATA  = 4'd2,
    MODE_STROBE   = 4'd3,
    MODE_READDATA = 4'd4,
    MODE_STATUS   = 4'd5,
    MODE_ATTN     = 4'd6,
    MODE_DEFER    = 4'd7,
    MODE_TXTICK   = 4'd8,
    MODE_RXTICK   = 4'd9,
    MODE_HOSTWORD = 4'd10
  } mode_t;

  localparam logic [1:0] CYC_1 = 2'd1;
  localparam logic [1:0] CYC_2 = 2'd2;
  localparam logic [1:0] CYC_3 = 2'd3;

  localparam logic REG_RESIDUE = 1'b0;

  function automatic logic [31:0] crc_word(input logic [31:0] c_in, input logic [15:0] w);
    logic [31:0] c;
    logic        fb;
    c = c_in;
    for (int k = 15; k >= 0; k--) begin
      fb = c[31] ^ w[k];
      c  = {c[30:0], 1'b0} ^ (fb ? CRC_POLY : 32'h0);
    end
    return c;
  endfunction

endpackage

// ===== rtl/wec_if.sv =====
// Input and result channel interfaces of the Ethernet controller register block.
interface wec_in_if;
  logic        valid;
  logic        ready;
  logic [3:0]  mode;
  logic [15:0] data;
  logic [1:0]  cycle;
  logic        host_last;
  logic        host_odd;
  modport source(output valid, mode, data, cycle, host_last, host_odd, input ready);
  modport sink(input valid, mode, data, cycle, host_last, host_odd, output ready);
endinterface

interface wec_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] read_data;
  logic        wake_request;
  logic        tx_word_valid;
  logic [15:0] tx_word;
  logic        tx_packet_end;
  logic        host_word_dropped;
  modport source(output valid, read_data, wake_request, tx_word_valid, tx_word,
                 tx_packet_end, host_word_dropped, input ready);
  modport sink(input valid, read_data, wake_request, tx_word_valid, tx_word,
               tx_packet_end, host_word_dropped, output ready);
endinterface

// ===== rtl/word_ethernet_controller_regs_top.sv =====
// Top level of the word-wide Ethernet controller register block.
// One item per clock unless the result channel stalls: each accepted microcode access,
// tick or host word updates all state at the accepting edge and loads its result into
// the output register; a new item is taken whenever that register is empty or being read.
// The shared FIFO sits in flip-flops, the loopback input buffer in a RAM whose head word is
// prefetched every cycle with a bypass for a word written to the head. The CRC-32 advances
// one 16-bit word for each received word written into the FIFO.
module word_ethernet_controller_regs_top #(
  parameter int unsigned FIFO_WORDS = wec_pkg::FIFO_WORDS_DEF,
  parameter int unsigned IBUF_WORDS = wec_pkg::IBUF_WORDS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  wec_in_if.sink            in_ch,
  wec_out_if.source         out_ch,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);
  import wec_pkg::*;

  localparam int unsigned FAW = $clog2(FIFO_WORDS);
  localparam int unsigned FCW = $clog2(FIFO_WORDS + 1);
  localparam int unsigned FSW = FCW + 1;
  localparam int unsigned IAW = $clog2(IBUF_WORDS);
  localparam int unsigned ICW = $clog2(IBUF_WORDS + 1);
  localparam int unsigned ISW = ICW + 1;

  logic [31:0] residue;

  logic en_tx, last_word, defer_on, en_rcv, turned_on, local_loop, loop_back;
  logic rx_even_len, rx_good_crc, rx_overrun, rx_good_align, tx_underrun, tx_collision, rx_mode;
  logic out_attn, in_attn, last_r_word;
  logic tx_running, rx_running, rx_pending, rx_in_data, even_len, defer_pending, wake;
  logic [15:0] fifo_mem [FIFO_WORDS];
  logic [FAW-1:0] fifo_rd;
  logic [FCW-1:0] fifo_cnt;
  logic [15:0] fifo_head_word;
  logic [15:0] out_word;
  logic        out_latched;
  logic [IAW-1:0] in_rd;
  logic [ICW-1:0] in_cnt;
  logic [31:0] crc_register;
  logic        byp_valid;
  logic [15:0] byp_data;
  logic [15:0] ram_q;

  logic en_tx_next, last_word_next, defer_on_next, en_rcv_next, turned_on_next;
  logic local_loop_next, loop_back_next;
  logic rx_even_len_next, rx_good_crc_next, rx_overrun_next, rx_good_align_next;
  logic tx_underrun_next, tx_collision_next, rx_mode_next;
  logic out_attn_next, in_attn_next, last_r_word_next;
  logic tx_running_next, rx_running_next, rx_pending_next, rx_in_data_next, even_len_next;
  logic defer_pending_next, wake_next;
  logic [FAW-1:0] fifo_rd_next;
  logic [FCW-1:0] fifo_cnt_next;
  logic [15:0] fifo_head_word_next, out_word_next;
  logic        out_latched_next;
  logic [IAW-1:0] in_rd_next;
  logic [ICW-1:0] in_cnt_next;
  logic [31:0] crc_register_next;

  logic           f_we;
  logic [FAW-1:0] f_wa;
  logic [15:0]    f_wd;
  logic           i_we;
  logic [IAW-1:0] i_wa;
  logic [15:0]    i_wd;
  logic [15:0]    in_head;

  logic [15:0] rd_c, txw_c;
  logic        txv_c, txend_c, drop_c;

  logic        out_valid;
  logic [15:0] o_read_data, o_tx_word;
  logic        o_wake, o_txv, o_txend, o_drop;

  logic in_fire;
  logic cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign prdata    = (paddr[2] == REG_RESIDUE) ? residue : 32'h0;

  assign in_ch.ready = !out_valid || out_ch.ready;
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign in_head     = byp_valid ? byp_data : ram_q;

  function automatic logic wake_fn(
    input logic e_tx, input logic d_on, input logic l_word, input logic [FCW-1:0] cnt,
    input logic tick, input logic r_mode, input logic lr_word, input logic o_attn,
    input logic i_attn
  );
    logic txw, dw, rxw;
    txw = e_tx && (cnt < FCW'(FIFO_WORDS)) && !d_on && !l_word;
    dw  = d_on && tick;
    rxw = !r_mode && ((cnt > FCW'(2)) || lr_word);
    return txw || dw || rxw || o_attn || i_attn;
  endfunction

  always_comb begin
    logic           loops;
    logic [FSW-1:0] fsum;
    logic [ISW-1:0] isum;
    logic [15:0]    w;
    logic [15:0]    sw;

    en_tx_next = en_tx; last_word_next = last_word; defer_on_next = defer_on;
    en_rcv_next = en_rcv; turned_on_next = turned_on; local_loop_next = local_loop;
    loop_back_next = loop_back;
    rx_even_len_next = rx_even_len; rx_good_crc_next = rx_good_crc;
    rx_overrun_next = rx_overrun; rx_good_align_next = rx_good_align;
    tx_underrun_next = tx_underrun; tx_collision_next = tx_collision; rx_mode_next = rx_mode;
    out_attn_next = out_attn; in_attn_next = in_attn; last_r_word_next = last_r_word;
    tx_running_next = tx_running; rx_running_next = rx_running; rx_pending_next = rx_pending;
    rx_in_data_next = rx_in_data; even_len_next = even_len;
    defer_pending_next = defer_pending; wake_next = wake;
    fifo_rd_next = fifo_rd; fifo_cnt_next = fifo_cnt; fifo_head_word_next = fifo_head_word;
    out_word_next = out_word; out_latched_next = out_latched;
    in_rd_next = in_rd; in_cnt_next = in_cnt; crc_register_next = crc_register;
    f_we = 1'b0; f_wa = '0; f_wd = '0;
    i_we = 1'b0; i_wa = '0; i_wd = '0;
    rd_c = '0; txw_c = '0; txv_c = 1'b0; txend_c = 1'b0; drop_c = 1'b0;
    loops = 1'b0; fsum = '0; isum = '0; w = '0; sw = '0;

    if (in_fire) begin
      case (in_ch.mode)
        MODE_OUTCTL: begin
          en_tx_next = in_ch.data[0];
          last_word_next = in_ch.data[1];
          defer_on_next = in_ch.data[2];
          out_attn_next = 1'b0;
          tx_underrun_next = 1'b0;
          tx_collision_next = 1'b1;
          defer_pending_next = in_ch.data[2];
          if (!in_ch.data[2] && in_ch.data[0] && !tx_running && !in_ch.data[1]) begin
            crc_register_next = CRC_PRESET;
            tx_running_next = 1'b1;
          end
          if (!in_ch.data[0]) begin
            fifo_rd_next = '0; fifo_cnt_next = '0; fifo_head_word_next = '0;
            tx_running_next = 1'b0;
          end
          wake_next = wake_fn(en_tx_next, defer_on_next, last_word_next, fifo_cnt_next, 1'b0,
                              rx_mode_next, last_r_word_next, out_attn_next, in_attn_next);
        end
        MODE_INCTL: begin
          en_rcv_next = in_ch.data[0];
          turned_on_next = !in_ch.data[1];
          local_loop_next = in_ch.data[2];
          loop_back_next = in_ch.data[3];
          if (!in_ch.data[0]) begin
            rx_mode_next = 1'b1;
            rx_in_data_next = 1'b0;
            in_attn_next = 1'b0;
            last_r_word_next = 1'b0;
            rx_good_crc_next = 1'b1; rx_good_align_next = 1'b1;
            rx_overrun_next = 1'b1; rx_even_len_next = 1'b1;
            if (!in_ch.data[3]) begin
              fifo_rd_next = '0; fifo_cnt_next = '0; fifo_head_word_next = '0;
            end
            in_rd_next = '0; in_cnt_next = '0;
            crc_register_next = CRC_PRESET;
          end
          wake_next = wake_fn(en_tx_next, defer_on_next, last_word_next, fifo_cnt_next, 1'b0,
                              rx_mode_next, last_r_word_next, out_attn_next, in_attn_next);
        end
        MODE_OUTDATA: begin
          out_word_next = in_ch.data;
          out_latched_next = 1'b1;
        end
        MODE_STROBE: begin
          if ((in_ch.cycle == CYC_1 || in_ch.cycle == CYC_3) && !last_word) begin
            if (!out_latched) out_attn_next = 1'b0;
            if (fifo_cnt < FCW'(FIFO_WORDS)) begin
              fsum = FSW'(fifo_rd) + FSW'(fifo_cnt);
              if (fsum >= FSW'(FIFO_WORDS)) fsum = fsum - FSW'(FIFO_WORDS);
              f_we = 1'b1; f_wa = fsum[FAW-1:0]; f_wd = out_word;
              fifo_cnt_next = fifo_cnt + FCW'(1);
              out_latched_next = 1'b0;
              out_attn_next = 1'b0;
              wake_next = wake_fn(en_tx, defer_on, last_word, fifo_cnt_next, 1'b0,
                                  rx_mode, last_r_word, out_attn_next, in_attn);
            end else begin
              // full: oldest word out, new word into its slot
              f_we = 1'b1; f_wa = fifo_rd; f_wd = out_word;
              fifo_rd_next = (fifo_rd == FAW'(FIFO_WORDS - 1)) ? '0 : fifo_rd + FAW'(1);
            end
          end else if (in_ch.cycle == CYC_2) begin
            in_rd_next = '0; in_cnt_next = '0;
            fifo_rd_next = '0; fifo_cnt_next = '0; fifo_head_word_next = '0;
            in_attn_next = 1'b0;
            last_r_word_next = 1'b0;
            rx_mode_next = 1'b1;
            rx_pending_next = 1'b0;
            rx_running_next = 1'b0;
            wake_next = wake_fn(en_tx, defer_on, last_word, '0, 1'b0,
                                1'b1, 1'b0, out_attn, 1'b0);
          end
        end
        MODE_READDATA: begin
          loops = loop_back || local_loop;
          if (fifo_cnt != '0) begin
            if (in_ch.cycle == CYC_2) begin
              fifo_head_word_next = fifo_mem[fifo_rd];
              fifo_rd_next = (fifo_rd == FAW'(FIFO_WORDS - 1)) ? '0 : fifo_rd + FAW'(1);
              fifo_cnt_next = fifo_cnt - FCW'(1);
            end
            rd_c = fifo_head_word_next;
          end
          if (fifo_cnt_next == '0 && (last_r_word || loops)) begin
            rx_running_next = 1'b0;
            last_r_word_next = 1'b0;
            in_attn_next = 1'b1;
            rx_mode_next = 1'b0;
            rx_good_crc_next = loops ? (crc_register == residue) : 1'b1;
            rx_even_len_next = loops ? 1'b1 : even_len;
          end
          wake_next = wake_fn(en_tx, defer_on, last_word, fifo_cnt_next, 1'b0,
                              rx_mode_next, last_r_word_next, out_attn, in_attn_next);
        end
        MODE_STATUS: begin
          sw = {3'b000, loop_back, local_loop, en_rcv, last_word, en_tx, rx_mode,
                tx_collision, !tx_underrun, rx_good_align, rx_overrun, rx_good_crc,
                rx_even_len, turned_on};
          rd_c = ~sw;
        end
        MODE_ATTN: begin
          rd_c = {15'h0, turned_on && (out_attn || in_attn)};
        end
        MODE_DEFER: begin
          if (defer_pending) begin
            defer_pending_next = 1'b0;
            wake_next = wake_fn(en_tx, defer_on, last_word, fifo_cnt, 1'b1,
                                rx_mode, last_r_word, out_attn, in_attn);
            if (en_tx) tx_running_next = 1'b1;
          end
        end
        MODE_TXTICK: begin
          if (tx_running) begin
            loops = loop_back || local_loop;
            if (fifo_cnt != '0) begin
              w = fifo_mem[fifo_rd];
              fifo_rd_next = (fifo_rd == FAW'(FIFO_WORDS - 1)) ? '0 : fifo_rd + FAW'(1);
              fifo_cnt_next = fifo_cnt - FCW'(1);
              if (loops) begin
                if (in_cnt < ICW'(IBUF_WORDS)) begin
                  isum = ISW'(in_rd) + ISW'(in_cnt);
                  if (isum >= ISW'(IBUF_WORDS)) isum = isum - ISW'(IBUF_WORDS);
                  i_we = 1'b1; i_wa = isum[IAW-1:0]; i_wd = w;
                  in_cnt_next = in_cnt + ICW'(1);
                end
                rx_mode_next = 1'b0;
                if (!rx_running && en_rcv) begin
                  rx_running_next = 1'b1;
                  rx_pending_next = 1'b1;
                end
              end else begin
                txv_c = 1'b1;
                txw_c = w;
              end
            end else if (!last_word) begin
              tx_underrun_next = 1'b1;
            end
            if (last_word && fifo_cnt_next == '0) begin
              tx_running_next = 1'b0;
              out_attn_next = 1'b1;
              txend_c = !loops;
            end else if (tx_underrun_next) begin
              tx_running_next = 1'b0;
            end
            wake_next = wake_fn(en_tx, defer_on, last_word, fifo_cnt_next, 1'b0,
                                rx_mode_next, last_r_word, out_attn_next, in_attn);
          end
        end
        MODE_RXTICK: begin
          if (rx_pending) begin
            if (in_cnt != '0) begin
              if (!rx_in_data) begin
                in_rd_next = (in_rd == IAW'(IBUF_WORDS - 1)) ? '0 : in_rd + IAW'(1);
                in_cnt_next = in_cnt - ICW'(1);
                if (in_head == START_DELIM) rx_in_data_next = 1'b1;
              end else if (fifo_cnt < FCW'(FIFO_WORDS)) begin
                in_rd_next = (in_rd == IAW'(IBUF_WORDS - 1)) ? '0 : in_rd + IAW'(1);
                in_cnt_next = in_cnt - ICW'(1);
                fsum = FSW'(fifo_rd) + FSW'(fifo_cnt);
                if (fsum >= FSW'(FIFO_WORDS)) fsum = fsum - FSW'(FIFO_WORDS);
                f_we = 1'b1; f_wa = fsum[FAW-1:0]; f_wd = in_head;
                fifo_cnt_next = fifo_cnt + FCW'(1);
                crc_register_next = crc_word(crc_register, in_head);
                wake_next = wake_fn(en_tx, defer_on, last_word, fifo_cnt_next, 1'b0,
                                    rx_mode, last_r_word, out_attn, in_attn);
              end
            end
            if (in_cnt_next == '0) begin
              rx_pending_next = 1'b0;
              last_r_word_next = 1'b1;
              wake_next = wake_fn(en_tx, defer_on, last_word, fifo_cnt_next, 1'b0,
                                  rx_mode, 1'b1, out_attn, in_attn);
            end
          end
        end
        MODE_HOSTWORD: begin
          if (!en_rcv || !turned_on || en_tx || tx_running || local_loop || loop_back
              || rx_running) begin
            drop_c = 1'b1;
          end else begin
            w = (in_ch.host_last && in_ch.host_odd) ? {in_ch.data[15:8], 8'h00} : in_ch.data;
            if (in_cnt < ICW'(IBUF_WORDS)) begin
              isum = ISW'(in_rd) + ISW'(in_cnt);
              if (isum >= ISW'(IBUF_WORDS)) isum = isum - ISW'(IBUF_WORDS);
              i_we = 1'b1; i_wa = isum[IAW-1:0]; i_wd = w;
              in_cnt_next = in_cnt + ICW'(1);
            end else begin
              drop_c = 1'b1;
            end
            if (in_ch.host_last) begin
              fifo_rd_next = '0; fifo_cnt_next = '0; fifo_head_word_next = '0;
              rx_in_data_next = 1'b1;
              even_len_next = !in_ch.host_odd;
              rx_mode_next = 1'b0;
              rx_running_next = 1'b1;
              rx_pending_next = 1'b1;
            end
          end
        end
        default: begin
          rd_c = '0;
        end
      endcase
    end
  end

  wec_ram #(.WIDTH(16), .DEPTH(IBUF_WORDS)) u_in_ram (
    .clk   (clk),
    .we    (i_we),
    .waddr (i_wa),
    .wdata (i_wd),
    .raddr (in_rd_next),
    .rdata (ram_q)
  );

  always_ff @(posedge clk) begin
    if (f_we) begin
      fifo_mem[f_wa] <= f_wd;
    end
    byp_data <= i_wd;
    if (in_fire) begin
      o_read_data <= rd_c;
      o_wake      <= wake_next;
      o_txv       <= txv_c;
      o_tx_word   <= txw_c;
      o_txend     <= txend_c;
      o_drop      <= drop_c;
    end
    if (rst) begin
      residue <= RESIDUE_RESET;
      en_tx <= 1'b0; last_word <= 1'b0; defer_on <= 1'b0; en_rcv <= 1'b0;
      turned_on <= 1'b0; local_loop <= 1'b0; loop_back <= 1'b0;
      rx_even_len <= 1'b0; rx_good_crc <= 1'b0; tx_underrun <= 1'b0;
      rx_overrun <= 1'b1; rx_good_align <= 1'b1; tx_collision <= 1'b1; rx_mode <= 1'b1;
      out_attn <= 1'b0; in_attn <= 1'b0; last_r_word <= 1'b0;
      tx_running <= 1'b0; rx_running <= 1'b0; rx_pending <= 1'b0; rx_in_data <= 1'b0;
      even_len <= 1'b0; defer_pending <= 1'b0; wake <= 1'b0;
      fifo_rd <= '0; fifo_cnt <= '0; out_latched <= 1'b0;
      in_rd <= '0; in_cnt <= '0;
      byp_valid <= 1'b0;
      out_valid <= 1'b0;
      fifo_head_word <= '0;
      out_word <= '0;
      crc_register <= CRC_PRESET;
    end else begin
      if (cfg_write && paddr[2] == REG_RESIDUE) residue <= pwdata;
      en_tx <= en_tx_next; last_word <= last_word_next; defer_on <= defer_on_next;
      en_rcv <= en_rcv_next; turned_on <= turned_on_next; local_loop <= local_loop_next;
      loop_back <= loop_back_next;
      rx_even_len <= rx_even_len_next; rx_good_crc <= rx_good_crc_next;
      rx_overrun <= rx_overrun_next; rx_good_align <= rx_good_align_next;
      tx_underrun <= tx_underrun_next; tx_collision <= tx_collision_next;
      rx_mode <= rx_mode_next;
      out_attn <= out_attn_next; in_attn <= in_attn_next; last_r_word <= last_r_word_next;
      tx_running <= tx_running_next; rx_running <= rx_running_next;
      rx_pending <= rx_pending_next; rx_in_data <= rx_in_data_next;
      even_len <= even_len_next; defer_pending <= defer_pending_next; wake <= wake_next;
      fifo_rd <= fifo_rd_next; fifo_cnt <= fifo_cnt_next; out_latched <= out_latched_next;
      in_rd <= in_rd_next; in_cnt <= in_cnt_next;
      fifo_head_word <= fifo_head_word_next;
      out_word       <= out_word_next;
      crc_register   <= crc_register_next;
      // forward a word written to the address being prefetched
      byp_valid <= i_we && (i_wa == in_rd_next);
      if (in_fire) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign out_ch.valid             = out_valid;
  assign out_ch.read_data         = o_read_data;
  assign out_ch.wake_request      = o_wake;
  assign out_ch.tx_word_valid     = o_txv;
  assign out_ch.tx_word           = o_tx_word;
  assign out_ch.tx_packet_end     = o_txend;
  assign out_ch.host_word_dropped = o_drop;
endmodule

// ===== rtl/wec_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module wec_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== rtl/wec_checker.sv =====
// Port-level checker for the Ethernet controller register block, bound to the top level.
module wec_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        tx_word_valid,
  input logic [15:0] tx_word
);
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result present right after reset");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");
  a_block: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready)
    else $error("transaction taken while result stalled");
  a_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> out_valid)
    else $error("accepted transaction gave no result");
  a_txword: assert property (@(posedge clk) disable iff (rst)
    out_valid && !tx_word_valid |-> tx_word == 16'h0)
    else $error("tx word nonzero without valid");
endmodule

bind word_ethernet_controller_regs_top wec_checker u_wec_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .tx_word_valid (out_ch.tx_word_valid),
  .tx_word       (out_ch.tx_word)
);

// ===== verif/wec_checker.sv =====
// Checker of the Ethernet controller register block: predicts each result and compares it.
module wec_scoreboard
  import wec_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  wec_in_if           mon_in,
  wec_out_if          mon_out,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output int          fails,
  output int          pending
);

  localparam int unsigned FW = FIFO_WORDS_DEF;
  localparam int unsigned PW = IBUF_WORDS_DEF;

  typedef struct packed {
    logic [15:0] read_data;
    logic        wake_request;
    logic        tx_word_valid;
    logic [15:0] tx_word;
    logic        tx_packet_end;
    logic        host_word_dropped;
  } wec_result_t;

  wec_result_t result_q[$];

  logic [31:0] residue;
  bit en_tx, last_word, defer_on, en_rcv, turned_on, local_loop, loop_back;
  bit rx_even_len, rx_good_crc, rx_overrun, rx_good_align, tx_underrun, tx_collision, rx_mode;
  bit out_attn, in_attn, last_r_word;
  logic [15:0] fifo_mem [FW];
  int unsigned fifo_rd, fifo_cnt;
  logic [15:0] fifo_head;
  logic [15:0] out_word;
  bit          out_latched;
  logic [15:0] in_mem [PW];
  int unsigned in_rd, in_cnt;
  logic [31:0] crc_reg;
  bit tx_running, rx_running, rx_pending, rx_in_data, even_len, defer_pending, wake;

  function void fifo_clear();
    fifo_rd = 0;
    fifo_cnt = 0;
    fifo_head = '0;
  endfunction

  function logic [15:0] fifo_pop();
    logic [15:0] w;
    w = fifo_mem[fifo_rd];
    fifo_rd = (fifo_rd + 1 >= FW) ? 0 : fifo_rd + 1;
    fifo_cnt--;
    return w;
  endfunction

  function void fifo_push(logic [15:0] w);
    fifo_mem[(fifo_rd + fifo_cnt) % FW] = w;
    fifo_cnt++;
  endfunction

  function logic [15:0] in_pop();
    logic [15:0] w;
    w = in_mem[in_rd];
    in_rd = (in_rd + 1 >= PW) ? 0 : in_rd + 1;
    in_cnt--;
    return w;
  endfunction

  function bit in_push(logic [15:0] w);
    if (in_cnt >= PW) return 0;
    in_mem[(in_rd + in_cnt) % PW] = w;
    in_cnt++;
    return 1;
  endfunction

  function void crc_advance(logic [15:0] w);
    logic [31:0] c;
    logic [7:0]  b;
    c = crc_reg;
    for (int i = 0; i < 2; i++) begin
      b = (i == 0) ? w[15:8] : w[7:0];
      c = c ^ {b, 24'h0};
      for (int k = 0; k < 8; k++) c = c[31] ? ({c[30:0], 1'b0} ^ CRC_POLY) : {c[30:0], 1'b0};
    end
    crc_reg = c;
  endfunction

  function void recompute_wake(bit tick);
    wake = (en_tx && fifo_cnt < FW && !defer_on && !last_word) || (defer_on && tick) ||
           (!rx_mode && (fifo_cnt > 2 || last_r_word)) || out_attn || in_attn;
  endfunction

  function void start_receiver();
    rx_mode = 0;
    if (!rx_running && en_rcv) begin
      rx_running = 1;
      rx_pending = 1;
    end
  endfunction

  function void reset_state();
    residue = RESIDUE_RESET;
    {en_tx, last_word, defer_on, en_rcv, turned_on, local_loop, loop_back} = '0;
    {rx_even_len, rx_good_crc, tx_underrun} = '0;
    {rx_overrun, rx_good_align, tx_collision, rx_mode} = '1;
    {out_attn, in_attn, last_r_word} = '0;
    fifo_clear();
    out_word = '0;
    out_latched = 0;
    in_rd = 0;
    in_cnt = 0;
    crc_reg = CRC_PRESET;
    {tx_running, rx_running, rx_pending, rx_in_data, even_len, defer_pending, wake} = '0;
  endfunction

  function logic [15:0] inverted_status();
    logic [15:0] v;
    v = {3'b0, loop_back, local_loop, en_rcv, last_word, en_tx, rx_mode, tx_collision,
         !tx_underrun, rx_good_align, rx_overrun, rx_good_crc, rx_even_len, turned_on};
    return ~v;
  endfunction

  function wec_result_t predict(logic [3:0] m, logic [15:0] d, logic [1:0] cyc, bit hl, bit ho);
    wec_result_t r;
    bit loops;
    logic [15:0] w;
    r = '0;
    loops = loop_back || local_loop;
    case (m)
      MODE_OUTCTL: begin
        en_tx = d[0];
        last_word = d[1];
        defer_on = d[2];
        out_attn = 0;
        tx_underrun = 0;
        tx_collision = 1;
        defer_pending = defer_on;
        if (!defer_on && en_tx && !tx_running && !last_word) begin
          crc_reg = CRC_PRESET;
          tx_running = 1;
        end
        if (!en_tx) begin
          fifo_clear();
          tx_running = 0;
        end
        recompute_wake(0);
      end
      MODE_INCTL: begin
        en_rcv = d[0];
        turned_on = !d[1];
        local_loop = d[2];
        loop_back = d[3];
        if (!en_rcv) begin
          rx_mode = 1;
          rx_in_data = 0;
          in_attn = 0;
          last_r_word = 0;
          {rx_good_crc, rx_good_align, rx_overrun, rx_even_len} = '1;
          if (!loop_back) fifo_clear();
          in_rd = 0;
          in_cnt = 0;
          crc_reg = CRC_PRESET;
        end
        recompute_wake(0);
      end
      MODE_OUTDATA: begin
        out_word = d;
        out_latched = 1;
      end
      MODE_STROBE: begin
        if ((cyc == CYC_1 || cyc == CYC_3) && !last_word) begin
          if (!out_latched) out_attn = 0;
          if (fifo_cnt < FW) begin
            fifo_push(out_word);
            out_latched = 0;
            out_attn = 0;
            recompute_wake(0);
          end else begin
            void'(fifo_pop());
            fifo_push(out_word);
          end
        end else if (cyc == CYC_2) begin
          in_rd = 0;
          in_cnt = 0;
          fifo_clear();
          in_attn = 0;
          last_r_word = 0;
          rx_mode = 1;
          rx_pending = 0;
          rx_running = 0;
          recompute_wake(0);
        end
      end
      MODE_READDATA: begin
        if (fifo_cnt > 0) begin
          if (cyc == CYC_2) fifo_head = fifo_pop();
          r.read_data = fifo_head;
        end
        if (fifo_cnt == 0 && (last_r_word || loops)) begin
          rx_running = 0;
          last_r_word = 0;
          in_attn = 1;
          rx_mode = 0;
          rx_good_crc = loops ? (crc_reg == residue) : 1'b1;
          rx_even_len = loops ? 1'b1 : even_len;
        end
        recompute_wake(0);
      end
      MODE_STATUS: r.read_data = inverted_status();
      MODE_ATTN: r.read_data = {15'b0, turned_on && (out_attn || in_attn)};
      MODE_DEFER: begin
        if (defer_pending) begin
          defer_pending = 0;
          recompute_wake(1);
          if (en_tx && !tx_running) tx_running = 1;
        end
      end
      MODE_TXTICK: begin
        if (tx_running) begin
          if (fifo_cnt > 0) begin
            w = fifo_pop();
            if (loops) begin
              void'(in_push(w));
              start_receiver();
            end else begin
              r.tx_word_valid = 1;
              r.tx_word = w;
            end
          end else if (!last_word) begin
            tx_underrun = 1;
          end
          if (last_word && fifo_cnt == 0) begin
            tx_running = 0;
            out_attn = 1;
            r.tx_packet_end = !loops;
          end else if (tx_underrun) begin
            tx_running = 0;
          end
          recompute_wake(0);
        end
      end
      MODE_RXTICK: begin
        if (rx_pending) begin
          if (in_cnt > 0) begin
            if (!rx_in_data) begin
              if (in_pop() == START_DELIM) rx_in_data = 1;
            end else if (fifo_cnt < FW) begin
              w = in_pop();
              fifo_push(w);
              crc_advance(w);
              recompute_wake(0);
            end
          end
          if (in_cnt == 0) begin
            rx_pending = 0;
            last_r_word = 1;
            recompute_wake(0);
          end
        end
      end
      MODE_HOSTWORD: begin
        if (!en_rcv || !turned_on || en_tx || tx_running || loops || rx_running) begin
          r.host_word_dropped = 1;
        end else begin
          w = (hl && ho) ? {d[15:8], 8'h00} : d;
          if (!in_push(w)) r.host_word_dropped = 1;
          if (hl) begin
            fifo_clear();
            rx_in_data = 1;
            even_len = !ho;
            start_receiver();
          end
        end
      end
      default: ;
    endcase
    r.wake_request = wake;
    return r;
  endfunction

  always @(posedge clk) begin
    wec_result_t got, want;
    if (rst) begin
      reset_state();
      result_q.delete();
      fails <= 0;
    end else begin
      if (psel && penable && pwrite && pready && paddr == 3'd0) residue = pwdata;
      if (mon_out.valid && mon_out.ready) begin
        got = {mon_out.read_data, mon_out.wake_request, mon_out.tx_word_valid, mon_out.tx_word,
               mon_out.tx_packet_end, mon_out.host_word_dropped};
        if (result_q.size() == 0) begin
          $error("unexpected transaction on result channel");
          fails <= fails + 1;
        end else begin
          want = result_q.pop_front();
          if (got != want) begin
            fails <= fails + 1;
            if (got.read_data != want.read_data)
              $error("read_data: expected %h, got %h", want.read_data, got.read_data);
            if (got.wake_request != want.wake_request)
              $error("wake_request: expected %b, got %b", want.wake_request, got.wake_request);
            if (got.tx_word_valid != want.tx_word_valid)
              $error("tx_word_valid: expected %b, got %b", want.tx_word_valid, got.tx_word_valid);
            if (got.tx_word != want.tx_word)
              $error("tx_word: expected %h, got %h", want.tx_word, got.tx_word);
            if (got.tx_packet_end != want.tx_packet_end)
              $error("tx_packet_end: expected %b, got %b", want.tx_packet_end, got.tx_packet_end);
            if (got.host_word_dropped != want.host_word_dropped)
              $error("host_word_dropped: expected %b, got %b",
                     want.host_word_dropped, got.host_word_dropped);
          end
        end
      end
      if (mon_in.valid && mon_in.ready)
        result_q.push_back(predict(mon_in.mode, mon_in.data, mon_in.cycle,
                                   mon_in.host_last, mon_in.host_odd));
    end
    pending <= result_q.size();
  end

endmodule

// ===== verif/tb_word_ethernet_controller_regs_top.sv =====
// Testbench top of the Ethernet controller register block: stimulus, configuration and verdict.
module tb_word_ethernet_controller_regs_top;
  import wec_pkg::*;

  logic        clk;
  logic        rst;
  logic        psel, penable, pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  int          fails;
  int          pending;
  int          items_sent;
  int          settings_used;
  int          cycle_count;
  bit          no_gaps;

  wec_in_if  in_ch();
  wec_out_if out_ch();

  word_ethernet_controller_regs_top i_dut (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  wec_scoreboard i_checker (
    .clk(clk), .rst(rst), .mon_in(in_ch), .mon_out(out_ch),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
    .paddr(paddr), .pwdata(pwdata), .fails(fails), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #50_000_000;
    $display("Regression FAIL");
    $finish;
  end

  always @(posedge clk) cycle_count <= rst ? 0 : cycle_count + 1;

  initial begin
    int r;
    bit long_done;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      r = $urandom_range(0, 99);
      if (!long_done && cycle_count >= 900) begin
        long_done = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (400) @(posedge clk);
      end else if (r < 3) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(5, 25)) @(posedge clk);
      end else begin
        out_ch.ready <= (r < 75) || no_gaps;
        @(posedge clk);
      end
    end
  end

  task automatic send(logic [3:0] m, logic [15:0] d, logic [1:0] c = 2'd0, bit hl = 1'b0,
                      bit ho = 1'b0);
    int r;
    bit acc;
    r = $urandom_range(0, 99);
    if (!no_gaps && r >= 60) begin
      in_ch.valid <= 1'b0;
      repeat (r < 95 ? $urandom_range(1, 3) : $urandom_range(5, 30)) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.mode      <= m;
    in_ch.data      <= d;
    in_ch.cycle     <= c;
    in_ch.host_last <= hl;
    in_ch.host_odd  <= ho;
    forever begin
      @(negedge clk);
      acc = in_ch.ready;
      @(posedge clk);
      if (acc) break;
    end
    items_sent++;
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_residue(logic [31:0] v);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= 3'd0;
    pwdata  <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    settings_used++;
  endtask

  task automatic tx_packet(bit with_defer);
    int n;
    n = $urandom_range(1, 12);
    send(MODE_OUTCTL, {13'($urandom_range(0, 8191)), with_defer, 2'b01});
    if (with_defer) send(MODE_DEFER, 16'($urandom));
    for (int i = 0; i < n; i++) begin
      send(MODE_OUTDATA, 16'($urandom));
      send(MODE_STROBE, 16'($urandom), $urandom_range(0, 1) ? CYC_1 : CYC_3);
      if ($urandom_range(0, 2) != 0) send(MODE_TXTICK, 16'($urandom));
    end
    send(MODE_OUTCTL, 16'h0003);
    for (int i = 0; i < n + 2; i++) send(MODE_TXTICK, 16'($urandom));
    send(MODE_ATTN, 16'($urandom));
    send(MODE_STATUS, 16'($urandom));
  endtask

  task automatic loop_packet();
    int n;
    n = $urandom_range(1, 10);
    send(MODE_INCTL, $urandom_range(0, 1) ? 16'h0009 : 16'h0005);
    send(MODE_OUTCTL, 16'h0001);
    for (int i = 0; i <= n; i++) begin
      send(MODE_OUTDATA, i == 0 ? START_DELIM : 16'($urandom));
      send(MODE_STROBE, 16'($urandom), CYC_1);
      send(MODE_TXTICK, 16'($urandom));
      send(MODE_RXTICK, 16'($urandom));
      send(MODE_RXTICK, 16'($urandom));
    end
    send(MODE_OUTCTL, 16'h0003);
    send(MODE_TXTICK, 16'($urandom));
    for (int i = 0; i < 3; i++) send(MODE_RXTICK, 16'($urandom));
    for (int i = 0; i < n + 2; i++) send(MODE_READDATA, 16'($urandom), CYC_2);
    send(MODE_ATTN, 16'($urandom));
    send(MODE_STATUS, 16'($urandom));
    send(MODE_INCTL, 16'h0000);
  endtask

  task automatic host_packet(int n);
    bit odd;
    odd = 1'($urandom_range(0, 1));
    send(MODE_OUTCTL, 16'h0000);
    send(MODE_INCTL, 16'h0001);
    for (int i = 0; i < n; i++)
      send(MODE_HOSTWORD, 16'($urandom), 2'($urandom), i == n - 1, odd);
    for (int i = 0; i < n + 2 && i < 40; i++) begin
      send(MODE_RXTICK, 16'($urandom));
      if ($urandom_range(0, 1))
        send(MODE_READDATA, 16'($urandom), $urandom_range(0, 1) ? CYC_2 : 2'd0);
    end
    for (int i = 0; i < 18; i++) send(MODE_READDATA, 16'($urandom), CYC_2);
    send(MODE_ATTN, 16'($urandom));
    send(MODE_STATUS, 16'($urandom));
  endtask

  task automatic noise();
    repeat ($urandom_range(1, 6))
      send(4'($urandom_range(0, 15)), 16'($urandom), 2'($urandom), 1'($urandom),
           1'($urandom));
  endtask

  initial begin
    logic [31:0] residues [4];
    int goal;
    int pick;
    residues = '{32'h0, 32'hFFFF_FFFF, $urandom, RESIDUE_RESET};
    items_sent = 0;
    settings_used = 0;
    no_gaps = 0;
    rst <= 1'b1;
    in_ch.valid <= 1'b0;
    in_ch.mode <= '0;
    in_ch.data <= '0;
    in_ch.cycle <= '0;
    in_ch.host_last <= 1'b0;
    in_ch.host_odd <= 1'b0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send(MODE_STATUS, 16'h0000);
    send(MODE_OUTCTL, 16'hFFFF);
    send(MODE_OUTCTL, 16'h0005);
    send(MODE_DEFER, 16'hFFFF);
    send(MODE_DEFER, 16'h0000);
    send(MODE_OUTDATA, 16'hFFFF);
    for (int c = 0; c < 4; c++) send(MODE_STROBE, 16'h0000, 2'(c));
    send(MODE_TXTICK, 16'h0000);
    send(MODE_INCTL, 16'hFFFF);
    send(MODE_INCTL, 16'h0001);
    send(MODE_HOSTWORD, 16'hFFFF, 2'd0, 1'b1, 1'b1);
    send(MODE_RXTICK, 16'h0000);
    for (int c = 0; c < 4; c++) send(MODE_READDATA, 16'h0000, 2'(c));
    send(MODE_ATTN, 16'hFFFF);
    send(MODE_STATUS, 16'hFFFF);
    send(4'd11, 16'hFFFF, 2'd3, 1'b1, 1'b1);
    send(4'd15, 16'h0000);
    drain();

    no_gaps = 1;
    host_packet(IBUF_WORDS_DEF + 4);
    no_gaps = 0;
    drain();

    for (int p = 0; p < 4; p++) begin
      write_residue(residues[p]);
      goal = items_sent + 120;
      no_gaps = (p == 2);
      while (items_sent < goal) begin
        pick = $urandom_range(0, 99);
        if (pick < 25) tx_packet($urandom_range(0, 3) == 0);
        else if (pick < 50) loop_packet();
        else if (pick < 75) host_packet($urandom_range(1, 14));
        else noise();
      end
      no_gaps = 0;
      drain();
    end

    $display("Sent %0d items under %0d residue settings; transmit, loopback, host receive,",
             items_sent, settings_used + 1);
    $display("input buffer overflow and random noise sequences were exercised.");
    if (fails == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
